/* rtl/grm_pkg.sv */
// shared types, codes and constants of the grid ray march column block
package grm_pkg;

    localparam int POS_W      = 14;
    localparam int DIR_W      = 16;
    localparam int DIR_FRAC   = 14;
    localparam int STEP_W     = 8;
    localparam int HALF_W     = 11;
    localparam int CFG_W      = 11;
    localparam int NUM_W      = 20;
    localparam int DIV_CNT_W  = 5;
    localparam int SHADE_W    = 15;
    localparam int TOP_W      = 15;
    localparam int BOT_W      = 14;
    localparam int COLOR_W    = 8;

    localparam logic [STEP_W-1:0] SPAN_SCALE  = 8'd7;
    localparam logic [STEP_W-1:0] SHADE_RANGE = 8'd160;
    localparam logic [STEP_W-1:0] RED_BASE    = 8'd136;
    localparam logic [STEP_W-1:0] GREEN_BASE  = 8'd69;
    localparam logic [STEP_W-1:0] BLUE_BASE   = 8'd53;
    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;

    localparam logic [1:0] CLS_FLOOR  = 2'd0;
    localparam logic [1:0] CLS_WALL   = 2'd1;
    localparam logic [1:0] CLS_PICKUP = 2'd2;
    localparam logic [1:0] CLS_ENEMY  = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    localparam logic REG_MAX_STEPS   = 1'b0;
    localparam logic REG_HALF_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARCH,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } grm_state_t;

    typedef struct packed {
        logic write;
        logic start;
        logic march;
        logic mul;
        logic div_step;
        logic load;
    } grm_cmd_t;

    typedef struct packed {
        logic march_hit;
        logic march_idle;
        logic div_last;
        logic out_free;
    } grm_sts_t;

    // floor(n / 160) for n below 21625: (n >> 5) / 5 by reciprocal 205 / 1024
    function automatic logic [COLOR_W-1:0] div160(input logic [SHADE_W-1:0] n);
        logic [9:0]  m;
        logic [17:0] p;
        m = n[SHADE_W-1:5];
        p = 18'(m) * 18'd205;
        return p[17:10];
    endfunction

endpackage

/* rtl/grm_ctrl.sv */
// controller state machine that sequences march, span division and result load
module grm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               kind,
    output logic               in_stall,
    input  grm_pkg::grm_sts_t  sts,
    output grm_pkg::grm_cmd_t  cmd
);

    grm_pkg::grm_state_t state_reg;
    grm_pkg::grm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            grm_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (kind == grm_pkg::KIND_CAST)
                    begin
                        cmd.start  = 1'b1;
                        state_next = grm_pkg::ST_MARCH;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            grm_pkg::ST_MARCH:
            begin
                cmd.march = 1'b1;
                if (sts.march_hit)
                begin
                    state_next = grm_pkg::ST_MUL;
                end
                else if (sts.march_idle)
                begin
                    state_next = grm_pkg::ST_LOAD;
                end
            end
            grm_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = grm_pkg::ST_DIV;
            end
            grm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = grm_pkg::ST_LOAD;
                end
            end
            grm_pkg::ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = grm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = grm_pkg::ST_IDLE;
            end
        endcase
    end

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == grm_pkg::ST_DIV && !sts.div_last) |=> state_reg == grm_pkg::ST_DIV)
        else $error("division left before its last step");

    a_hit_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == grm_pkg::ST_MARCH && sts.march_hit) |=> state_reg == grm_pkg::ST_MUL)
        else $error("hit did not start span computation");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sts.out_free)
        else $error("result loaded over a waiting word");

endmodule

/* rtl/grm_datapath.sv */
// map memory, ray march pipeline, span divider, shading and output register
module grm_datapath #(
    parameter int MAP_DIM       = 64,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  grm_pkg::grm_cmd_t             cmd,
    output grm_pkg::grm_sts_t             sts,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [grm_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [5:0]                    cell_x,
    input  logic [5:0]                    cell_y,
    input  logic [1:0]                    cell_class,
    input  logic [grm_pkg::POS_W-1:0]     pos_x,
    input  logic [grm_pkg::POS_W-1:0]     pos_y,
    input  logic signed [grm_pkg::DIR_W-1:0] dir_x,
    input  logic signed [grm_pkg::DIR_W-1:0] dir_y,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [1:0]                    hit_class,
    output logic [grm_pkg::STEP_W-1:0]    distance,
    output logic signed [grm_pkg::TOP_W-1:0] span_top,
    output logic [grm_pkg::BOT_W-1:0]     span_bottom,
    output logic [grm_pkg::COLOR_W-1:0]   red,
    output logic [grm_pkg::COLOR_W-1:0]   green,
    output logic [grm_pkg::COLOR_W-1:0]   blue
);

    localparam int CW    = $clog2(MAP_DIM);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int UPS   = grm_pkg::DIR_FRAC - POS_FRAC_BITS;
    localparam int ORG_W = grm_pkg::POS_W + UPS;
    localparam int DT_W  = grm_pkg::DIR_FRAC + grm_pkg::STEP_W;
    localparam int ACC_W = ((ORG_W > DT_W) ? ORG_W : DT_W) + 2;
    localparam int UW    = ACC_W - 1 - grm_pkg::DIR_FRAC;

    // configuration
    logic [grm_pkg::STEP_W-1:0] max_steps_reg;
    logic [grm_pkg::HALF_W-1:0] half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg <= grm_pkg::SHADE_RANGE;
            half_reg      <= 11'd384;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == grm_pkg::REG_MAX_STEPS)
            begin
                max_steps_reg <= cfg_wdata[grm_pkg::STEP_W-1:0];
            end
            else
            begin
                half_reg <= cfg_wdata[grm_pkg::HALF_W-1:0];
            end
        end
    end

    // map memory, index {x, y}
    logic [1:0]    map_mem [DEPTH];
    logic [1:0]    map_q_reg;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    assign wr_addr = {CW'(cell_x), CW'(cell_y)};
    assign wr_en   = cmd.write && (9'(cell_x) < 9'(MAP_DIM)) && (9'(cell_y) < 9'(MAP_DIM));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= cell_class;
        end
    end

    always_ff @(posedge clk)
    begin
        map_q_reg <= map_mem[rd_addr];
    end

    // march: issue stage reads the cell at the running point, check stage classifies it
    logic signed [ACC_W-1:0]    acc_x_reg, acc_y_reg;
    logic signed [ACC_W-1:0]    dx_reg, dy_reg;
    logic signed [ACC_W-1:0]    org_x, org_y, dir_x_ext, dir_y_ext;
    logic [grm_pkg::STEP_W-1:0] step_reg;
    logic                       issue_reg;
    logic                       s1_valid_reg;
    logic                       s1_oob_reg;
    logic [grm_pkg::STEP_W-1:0] s1_step_reg;
    logic [1:0]                 hit_cls_reg;
    logic [grm_pkg::STEP_W-1:0] dist_reg;
    logic [UW-1:0]              hi_x, hi_y;
    logic                       in_map;
    logic [1:0]                 cls_now;
    logic                       hit_now;

    assign org_x     = $signed(ACC_W'({pos_x, {UPS{1'b0}}}));
    assign org_y     = $signed(ACC_W'({pos_y, {UPS{1'b0}}}));
    assign dir_x_ext = {{(ACC_W-grm_pkg::DIR_W){dir_x[grm_pkg::DIR_W-1]}}, dir_x};
    assign dir_y_ext = {{(ACC_W-grm_pkg::DIR_W){dir_y[grm_pkg::DIR_W-1]}}, dir_y};

    assign hi_x    = acc_x_reg[ACC_W-2:grm_pkg::DIR_FRAC];
    assign hi_y    = acc_y_reg[ACC_W-2:grm_pkg::DIR_FRAC];
    assign in_map  = !acc_x_reg[ACC_W-1] && !acc_y_reg[ACC_W-1]
                     && (hi_x < UW'(MAP_DIM)) && (hi_y < UW'(MAP_DIM));
    assign rd_addr = {acc_x_reg[grm_pkg::DIR_FRAC+CW-1:grm_pkg::DIR_FRAC],
                      acc_y_reg[grm_pkg::DIR_FRAC+CW-1:grm_pkg::DIR_FRAC]};

    assign cls_now = s1_oob_reg ? grm_pkg::CLS_WALL : map_q_reg;
    assign hit_now = s1_valid_reg && (cls_now != grm_pkg::CLS_FLOOR);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_x_reg <= org_x + dir_x_ext;
            acc_y_reg <= org_y + dir_y_ext;
            dx_reg    <= dir_x_ext;
            dy_reg    <= dir_y_ext;
            step_reg  <= 8'd1;
        end
        else if (cmd.march && issue_reg)
        begin
            acc_x_reg   <= acc_x_reg + dx_reg;
            acc_y_reg   <= acc_y_reg + dy_reg;
            step_reg    <= step_reg + 8'd1;
            s1_oob_reg  <= !in_map;
            s1_step_reg <= step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            hit_cls_reg  <= grm_pkg::CLS_FLOOR;
            dist_reg     <= '0;
        end
        else if (cmd.start)
        begin
            issue_reg    <= (max_steps_reg != '0);
            s1_valid_reg <= 1'b0;
            hit_cls_reg  <= grm_pkg::CLS_FLOOR;
            dist_reg     <= '0;
        end
        else if (cmd.march)
        begin
            if (hit_now)
            begin
                hit_cls_reg  <= cls_now;
                dist_reg     <= s1_step_reg;
                issue_reg    <= 1'b0;
                s1_valid_reg <= 1'b0;
            end
            else
            begin
                s1_valid_reg <= issue_reg;
                if (issue_reg)
                begin
                    issue_reg <= (step_reg != max_steps_reg);
                end
            end
        end
    end

    // span: two restoring dividers by the hit distance, one quotient bit a cycle
    logic [8:0]                    span_add, span_sub;
    logic                          top_neg_reg;
    logic [grm_pkg::NUM_W-1:0]     num_bot_reg, num_top_reg;
    logic [grm_pkg::STEP_W-1:0]    rem_bot_reg, rem_top_reg;
    logic [grm_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [8:0]                    sh_bot, sh_top;
    logic [8:0]                    dvs;
    logic                          ge_bot, ge_top;
    logic [grm_pkg::STEP_W-1:0]    shade_k;
    logic [grm_pkg::SHADE_W-1:0]   shade_r_reg, shade_g_reg, shade_b_reg;

    assign span_add = 9'(dist_reg) + 9'(grm_pkg::SPAN_SCALE);
    assign span_sub = (dist_reg >= grm_pkg::SPAN_SCALE)
                      ? 9'(dist_reg - grm_pkg::SPAN_SCALE)
                      : 9'(grm_pkg::SPAN_SCALE - dist_reg);
    assign shade_k  = (dist_reg <= grm_pkg::SHADE_RANGE) ? (grm_pkg::SHADE_RANGE - dist_reg)
                                                        : '0;

    assign dvs    = {1'b0, dist_reg};
    assign sh_bot = {rem_bot_reg, num_bot_reg[grm_pkg::NUM_W-1]};
    assign sh_top = {rem_top_reg, num_top_reg[grm_pkg::NUM_W-1]};
    assign ge_bot = (sh_bot >= dvs);
    assign ge_top = (sh_top >= dvs);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            num_bot_reg <= grm_pkg::NUM_W'(half_reg) * grm_pkg::NUM_W'(span_add);
            num_top_reg <= grm_pkg::NUM_W'(half_reg) * grm_pkg::NUM_W'(span_sub);
            rem_bot_reg <= '0;
            rem_top_reg <= '0;
            top_neg_reg <= (dist_reg < grm_pkg::SPAN_SCALE);
            shade_r_reg <= grm_pkg::SHADE_W'(grm_pkg::RED_BASE) * grm_pkg::SHADE_W'(shade_k);
            shade_g_reg <= grm_pkg::SHADE_W'(grm_pkg::GREEN_BASE) * grm_pkg::SHADE_W'(shade_k);
            shade_b_reg <= grm_pkg::SHADE_W'(grm_pkg::BLUE_BASE) * grm_pkg::SHADE_W'(shade_k);
        end
        else if (cmd.div_step)
        begin
            num_bot_reg <= {num_bot_reg[grm_pkg::NUM_W-2:0], ge_bot};
            num_top_reg <= {num_top_reg[grm_pkg::NUM_W-2:0], ge_top};
            rem_bot_reg <= ge_bot ? 8'(sh_bot - dvs) : sh_bot[7:0];
            rem_top_reg <= ge_top ? 8'(sh_top - dvs) : sh_top[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.mul)
        begin
            div_cnt_reg <= grm_pkg::DIV_CNT_W'(grm_pkg::NUM_W - 1);
        end
        else if (cmd.div_step && div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // output register
    logic                              out_valid_reg;
    logic [1:0]                        hit_class_reg;
    logic [grm_pkg::STEP_W-1:0]        distance_reg;
    logic signed [grm_pkg::TOP_W-1:0]  span_top_reg;
    logic [grm_pkg::BOT_W-1:0]         span_bottom_reg;
    logic [grm_pkg::COLOR_W-1:0]       red_reg, green_reg, blue_reg;
    logic signed [grm_pkg::TOP_W-1:0]  top_mag;

    assign top_mag = $signed({1'b0, num_top_reg[grm_pkg::TOP_W-2:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hit_class_reg <= hit_cls_reg;
            distance_reg  <= dist_reg;
            if (hit_cls_reg != grm_pkg::CLS_FLOOR)
            begin
                span_top_reg    <= top_neg_reg ? -top_mag : top_mag;
                span_bottom_reg <= num_bot_reg[grm_pkg::BOT_W-1:0];
            end
            else
            begin
                span_top_reg    <= '0;
                span_bottom_reg <= '0;
            end
            case (hit_cls_reg)
                grm_pkg::CLS_WALL:
                begin
                    red_reg   <= grm_pkg::div160(shade_r_reg);
                    green_reg <= grm_pkg::div160(shade_g_reg);
                    blue_reg  <= grm_pkg::div160(shade_b_reg);
                end
                grm_pkg::CLS_PICKUP:
                begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= grm_pkg::COLOR_FULL;
                end
                grm_pkg::CLS_ENEMY:
                begin
                    red_reg   <= grm_pkg::COLOR_FULL;
                    green_reg <= '0;
                    blue_reg  <= '0;
                end
                default:
                begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit_class   = hit_class_reg;
    assign distance    = distance_reg;
    assign span_top    = span_top_reg;
    assign span_bottom = span_bottom_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

    always_comb
    begin
        sts.march_hit  = hit_now;
        sts.march_idle = !issue_reg && !s1_valid_reg;
        sts.div_last   = (div_cnt_reg == '0);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> (step_reg != '0 && step_reg <= max_steps_reg))
        else $error("march issued a step beyond the limit");

    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_cls_reg != grm_pkg::CLS_FLOOR) |-> (dist_reg != '0))
        else $error("hit captured with zero distance");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load))
        else $error("result word appeared without a load");

endmodule

/* rtl/grid_ray_march_column_top.sv */
// top level of the grid ray march column block
// a write word is taken in idle; a cast marches until a hit or the step limit,
// then runs one multiply, the span division and one load (one map read a cycle plus one
// check stage, one quotient bit a cycle); with no hit it goes straight to the load
// the load waits until the output register is free, and the next word waits for the load
// reset clears control and loads max_steps 160 and half height 384; map contents are undefined
module grid_ray_march_column_top #(
    parameter int MAP_DIM       = 64,
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [grm_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic [5:0]                       cell_x,
    input  logic [5:0]                       cell_y,
    input  logic [1:0]                       cell_class,
    input  logic [grm_pkg::POS_W-1:0]        pos_x,
    input  logic [grm_pkg::POS_W-1:0]        pos_y,
    input  logic signed [grm_pkg::DIR_W-1:0] dir_x,
    input  logic signed [grm_pkg::DIR_W-1:0] dir_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       hit_class,
    output logic [grm_pkg::STEP_W-1:0]       distance,
    output logic signed [grm_pkg::TOP_W-1:0] span_top,
    output logic [grm_pkg::BOT_W-1:0]        span_bottom,
    output logic [grm_pkg::COLOR_W-1:0]      red,
    output logic [grm_pkg::COLOR_W-1:0]      green,
    output logic [grm_pkg::COLOR_W-1:0]      blue
);

    grm_pkg::grm_cmd_t cmd;
    grm_pkg::grm_sts_t sts;

    grm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    grm_datapath #(
        .MAP_DIM       (MAP_DIM),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_class  (cell_class),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .hit_class   (hit_class),
        .distance    (distance),
        .span_top    (span_top),
        .span_bottom (span_bottom),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

endmodule
